FILE: rtl/adfp_pkg.sv
// ----------------------------------------------------------------------------
// ASCII decimal parser package
// Shared types and constants: parse phases, character codes, output width.
// ----------------------------------------------------------------------------
package adfp_pkg;

	localparam int CHAR_BITS = 8;
	localparam int OUT_BITS  = 48;
	localparam int DIGIT_BITS = 4;
	localparam int COUNT_BITS = 3;

	typedef logic [CHAR_BITS-1:0] char_t;

	typedef enum logic [1:0] {
		PH_SKIP = 2'd0,
		PH_INT  = 2'd1,
		PH_FRAC = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_DOT   = 8'h2E;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;

endpackage

FILE: rtl/adfp_char_if.sv
// ----------------------------------------------------------------------------
// Character stream interface
// Valid/ready channel carrying one ASCII character per beat.
// ----------------------------------------------------------------------------
interface adfp_char_if
	import adfp_pkg::*;
();
	logic  valid;
	logic  ready;
	char_t ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

FILE: rtl/adfp_result_if.sv
// ----------------------------------------------------------------------------
// Parsed value interface
// Valid/ready channel carrying one fixed-point value and its clamp flag per beat.
// ----------------------------------------------------------------------------
interface adfp_result_if
	import adfp_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] value;
	logic                       saturated;

	modport source (output valid, output value, output saturated, input ready);
	modport sink (input valid, input value, input saturated, output ready);
endinterface

FILE: rtl/adfp_emit.sv
// ----------------------------------------------------------------------------
// Result formatter
// Joins the integer and fraction accumulators, clamps the magnitude to the
// output range and applies the sign.
// ----------------------------------------------------------------------------
module adfp_emit
	import adfp_pkg::*;
#(
	parameter int INT_BITS  = 31,
	parameter int FRAC_BITS = 16
) (
	input  logic [INT_BITS-1:0]        int_acc,
	input  logic [FRAC_BITS+1:0]       frac_acc,
	input  logic                       overflowed,
	input  logic                       negative,
	output logic signed [OUT_BITS-1:0] value,
	output logic                       saturated
);
	localparam int W = (INT_BITS + FRAC_BITS + 1 > OUT_BITS) ?
		INT_BITS + FRAC_BITS + 1 : OUT_BITS;
	localparam int LIM_EXP = (INT_BITS + FRAC_BITS >= OUT_BITS - 1) ?
		OUT_BITS - 1 : INT_BITS + FRAC_BITS;
	localparam logic [W-1:0] LIM     = (W'(1) << LIM_EXP) - W'(1);
	localparam logic [W-1:0] LIM_INT = LIM >> FRAC_BITS;

	logic [W-1:0]        int_wide;
	logic [W-1:0]        mag_sum;
	logic [OUT_BITS-1:0] mag;
	logic                clamp;

	always_comb begin
		int_wide = W'(int_acc);
		mag_sum  = (int_wide << FRAC_BITS) + W'(frac_acc);
		clamp    = (int_wide > LIM_INT) || (mag_sum > LIM);
		mag      = clamp ? LIM[OUT_BITS-1:0] : mag_sum[OUT_BITS-1:0];
		value    = negative ? -$signed(mag) : $signed(mag);
		saturated = overflowed || clamp;
	end
endmodule

FILE: rtl/ascii_decimal_to_fixed_parser_core.sv
// ----------------------------------------------------------------------------
// ASCII decimal to fixed-point parser
// Parses a NUL-terminated decimal string, one character per beat, into a
// signed fixed-point value with FRAC_BITS fraction bits.
//
//   Channel  | Dir | Payload                         | Beat
//   chars    | in  | ch[7:0]                         | one character
//   results  | out | value[47:0] signed, saturated   | one parsed number
//
// A character is registered on acceptance and processed from the input
// register; the character that ends a number sends it to the result
// register. One character is taken every cycle while results is not
// stalled. The accumulator update (a multiply by ten and one add) lies
// between the input register and the accumulators, the output clamp
// between the accumulators and the result register. Reset returns the
// parser to skipping leading whitespace and empties both registers. A
// stall on results holds the input register and, through it, chars.ready.
// ----------------------------------------------------------------------------
module ascii_decimal_to_fixed_parser_core
	import adfp_pkg::*;
#(
	parameter int INT_BITS        = 31,
	parameter int FRAC_BITS       = 16,
	parameter int MAX_FRAC_DIGITS = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	adfp_char_if.sink      chars,
	adfp_result_if.source  results
);
	localparam int IW  = INT_BITS + DIGIT_BITS;
	localparam int FW  = FRAC_BITS + 2;
	localparam int PW  = FRAC_BITS + DIGIT_BITS;
	localparam logic [63:0] ONE_X2 = 64'd1 << (FRAC_BITS + 1);
	localparam logic [FRAC_BITS-1:0] FRAC_T [8] = '{
		FRAC_BITS'(((ONE_X2 / 64'd10) + 64'd1) >> 1),
		FRAC_BITS'(((ONE_X2 / 64'd100) + 64'd1) >> 1),
		FRAC_BITS'(((ONE_X2 / 64'd1000) + 64'd1) >> 1),
		FRAC_BITS'(((ONE_X2 / 64'd10000) + 64'd1) >> 1),
		FRAC_BITS'(((ONE_X2 / 64'd100000) + 64'd1) >> 1),
		FRAC_BITS'(((ONE_X2 / 64'd1000000) + 64'd1) >> 1),
		FRAC_BITS'(((ONE_X2 / 64'd10000000) + 64'd1) >> 1),
		FRAC_BITS'(0)
	};
	localparam logic [IW-1:0] INT_TOP = IW'({INT_BITS{1'b1}});
	localparam logic [COUNT_BITS-1:0] MAX_CNT = COUNT_BITS'(MAX_FRAC_DIGITS);

	logic  valid_s1;
	char_t ch_s1;
	logic  advance;

	phase_t                phase_q, phase_d;
	logic                  negative_q, negative_d;
	logic [INT_BITS-1:0]   int_acc_q, int_acc_d;
	logic [FW-1:0]         frac_acc_q, frac_acc_d;
	logic [COUNT_BITS-1:0] frac_count_q, frac_count_d;
	logic                  overflowed_q, overflowed_d;

	logic                       out_valid_q;
	logic signed [OUT_BITS-1:0] value_q;
	logic                       saturated_q;

	logic                       emit;
	logic                       is_digit;
	logic [DIGIT_BITS-1:0]      digit;
	logic [IW-1:0]              int_next;
	logic [FRAC_BITS+DIGIT_BITS-1:0] frac_prod;
	logic signed [OUT_BITS-1:0] emit_value;
	logic                       emit_saturated;
	phase_t                     phase_eff;
	logic                       taken;

	assign advance       = !out_valid_q || results.ready;
	assign chars.ready   = !valid_s1 || advance;
	assign results.valid = out_valid_q;
	assign results.value = value_q;
	assign results.saturated = saturated_q;

	assign is_digit  = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
	assign digit     = ch_s1[DIGIT_BITS-1:0];
	assign int_next  = (IW'(int_acc_q) << 3) + (IW'(int_acc_q) << 1) + IW'(digit);
	assign frac_prod = PW'(FRAC_T[frac_count_q]) * PW'(digit);

	adfp_emit #(
		.INT_BITS  (INT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_emit (
		.int_acc    (int_acc_q),
		.frac_acc   (frac_acc_q),
		.overflowed (overflowed_q),
		.negative   (negative_q),
		.value      (emit_value),
		.saturated  (emit_saturated)
	);

	always_comb begin
		phase_d      = phase_q;
		negative_d   = negative_q;
		int_acc_d    = int_acc_q;
		frac_acc_d   = frac_acc_q;
		frac_count_d = frac_count_q;
		overflowed_d = overflowed_q;
		emit         = 1'b0;
		taken        = 1'b0;
		phase_eff    = phase_q;

		if (phase_q == PH_DONE) begin
			taken = 1'b1;
		end else if (phase_q == PH_SKIP) begin
			if (ch_s1 == CH_SPACE || ch_s1 == CH_TAB) begin
				taken = 1'b1;
			end else if (ch_s1 == CH_MINUS) begin
				negative_d = 1'b1;
				phase_d    = PH_INT;
				taken      = 1'b1;
			end else if (ch_s1 == CH_PLUS) begin
				phase_d = PH_INT;
				taken   = 1'b1;
			end else begin
				phase_eff = PH_INT;
				phase_d   = PH_INT;
			end
		end

		if (!taken) begin
			if (phase_eff == PH_INT) begin
				if (is_digit) begin
					if (overflowed_q || int_next > INT_TOP) begin
						int_acc_d    = INT_TOP[INT_BITS-1:0];
						overflowed_d = 1'b1;
					end else begin
						int_acc_d = int_next[INT_BITS-1:0];
					end
				end else if (ch_s1 == CH_DOT) begin
					phase_d = PH_FRAC;
				end else begin
					emit = 1'b1;
				end
			end else if (is_digit) begin
				if (frac_count_q < MAX_CNT) begin
					frac_acc_d   = frac_acc_q + FW'(frac_prod);
					frac_count_d = frac_count_q + COUNT_BITS'(1);
				end
			end else begin
				emit = 1'b1;
			end
			if (emit) begin
				phase_d = PH_DONE;
			end
		end

		// The end of the string always re-arms the parser for the next one.
		if ((phase_q == PH_DONE || emit) && ch_s1 == CH_NUL) begin
			phase_d      = PH_SKIP;
			negative_d   = 1'b0;
			int_acc_d    = '0;
			frac_acc_d   = '0;
			frac_count_d = '0;
			overflowed_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1 <= chars.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SKIP;
			negative_q   <= 1'b0;
			int_acc_q    <= '0;
			frac_acc_q   <= '0;
			frac_count_q <= '0;
			overflowed_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			phase_q      <= phase_d;
			negative_q   <= negative_d;
			int_acc_q    <= int_acc_d;
			frac_acc_q   <= frac_acc_d;
			frac_count_q <= frac_count_d;
			overflowed_q <= overflowed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			value_q     <= emit_value;
			saturated_q <= emit_saturated;
		end
	end
endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the ASCII decimal to fixed-point parser
// Sends NUL-terminated strings one character per beat and predicts each
// parsed number in a behavioural parser of its own. Every result beat is
// checked field by field against the oldest predicted number. Directed
// strings cover the special cases. Random strings, mostly well formed with
// some noise, are then sent under three settings of sender and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb;
	import adfp_pkg::*;

	localparam int INT_BITS        = 31;
	localparam int FRAC_BITS       = 16;
	localparam int MAX_FRAC_DIGITS = 6;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int PHASE_CHARS     = 300;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] value;
		logic                       saturated;
	} number_t;

	typedef struct packed {
		char_t ch;
		logic  drain_first;
	} char_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	adfp_char_if   chars();
	adfp_result_if results();

	ascii_decimal_to_fixed_parser_core #(
		.INT_BITS(INT_BITS),
		.FRAC_BITS(FRAC_BITS),
		.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.results(results)
	);

	char_beat_t char_stream[$];
	number_t    pending_numbers[$];

	int tx_idle_pct;
	int rx_idle_pct;
	bit char_taken;
	bit drain_next;
	int errors;
	int cycles;
	int chars_sent;
	int strings_queued;
	int numbers_checked;
	int clamped_seen;

	phase_t          parse_phase;
	bit              is_negative;
	longint unsigned whole_part;
	longint unsigned frac_part;
	int              frac_digits;
	bit              whole_clamped;

	always #4 clk = ~clk;

	function automatic void clear_parser();
		parse_phase   = PH_SKIP;
		is_negative   = 1'b0;
		whole_part    = 0;
		frac_part     = 0;
		frac_digits   = 0;
		whole_clamped = 1'b0;
	endfunction

	function automatic bit is_digit(char_t c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic longint unsigned frac_weight(int k);
		longint unsigned p;
		p = 1;
		for (int i = 0; i < k; i++)
			p = p * 10;
		return ((64'd1 << (FRAC_BITS + 1)) / p + 1) >> 1;
	endfunction

	function automatic number_t finish_number();
		longint unsigned lim;
		longint unsigned mag;
		number_t n;
		n.saturated = whole_clamped;
		if (INT_BITS + FRAC_BITS >= OUT_BITS - 1)
			lim = (64'd1 << (OUT_BITS - 1)) - 1;
		else
			lim = (64'd1 << (INT_BITS + FRAC_BITS)) - 1;
		if (whole_part > (lim >> FRAC_BITS)) begin
			mag = lim;
			n.saturated = 1'b1;
		end else begin
			mag = (whole_part << FRAC_BITS) + frac_part;
			if (mag > lim) begin
				mag = lim;
				n.saturated = 1'b1;
			end
		end
		if (is_negative)
			mag = -mag;
		n.value = mag[OUT_BITS-1:0];
		return n;
	endfunction

	// Returns 1 when the character completes a number, which is then in n.
	function automatic bit parse_char(input char_t c, output number_t n);
		longint unsigned top;
		longint unsigned next_whole;
		n = '0;
		top = (64'd1 << INT_BITS) - 1;
		if (parse_phase == PH_DONE) begin
			if (c == CH_NUL)
				clear_parser();
			return 1'b0;
		end
		if (parse_phase == PH_SKIP) begin
			if (c == CH_SPACE || c == CH_TAB)
				return 1'b0;
			if (c == CH_MINUS) begin
				is_negative = 1'b1;
				parse_phase = PH_INT;
				return 1'b0;
			end
			if (c == CH_PLUS) begin
				parse_phase = PH_INT;
				return 1'b0;
			end
			parse_phase = PH_INT;
		end
		if (parse_phase == PH_INT) begin
			if (is_digit(c)) begin
				next_whole = whole_part * 10 + 64'(c - CH_ZERO);
				if (whole_clamped || next_whole > top) begin
					whole_part = top;
					whole_clamped = 1'b1;
				end else begin
					whole_part = next_whole;
				end
				return 1'b0;
			end
			if (c == CH_DOT) begin
				parse_phase = PH_FRAC;
				return 1'b0;
			end
		end else if (is_digit(c)) begin
			if (frac_digits < MAX_FRAC_DIGITS) begin
				frac_part = frac_part + 64'(c - CH_ZERO) * frac_weight(frac_digits + 1);
				frac_digits++;
			end
			return 1'b0;
		end
		n = finish_number();
		if (c == CH_NUL)
			clear_parser();
		else
			parse_phase = PH_DONE;
		return 1'b1;
	endfunction

	function automatic void push_char(char_t c);
		char_beat_t b;
		b.ch = c;
		b.drain_first = drain_next;
		drain_next = 1'b0;
		char_stream.push_back(b);
		if (c == CH_NUL)
			strings_queued++;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_char(char_t'(s[i]));
		push_char(CH_NUL);
	endfunction

	function automatic void push_digits(int count);
		for (int i = 0; i < count; i++)
			push_char(char_t'(CH_ZERO + $urandom_range(9)));
	endfunction

	function automatic void push_random_string();
		int kind;
		int n;
		if ($urandom_range(19) == 0)
			drain_next = 1'b1;
		kind = $urandom_range(9);
		if (kind == 0) begin
			n = $urandom_range(6, 1);
			for (int i = 0; i < n; i++)
				push_char(char_t'($urandom_range(255, 1)));
			push_char(CH_NUL);
			return;
		end
		if (kind == 1) begin
			n = $urandom_range(4, 1);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(3))
					0: push_char(CH_MINUS);
					1: push_char(CH_PLUS);
					2: push_char(CH_DOT);
					default: push_char(CH_SPACE);
				endcase
			end
			push_digits($urandom_range(2));
			push_char(CH_NUL);
			return;
		end
		n = $urandom_range(2);
		for (int i = 0; i < n; i++)
			push_char($urandom_range(1) ? CH_SPACE : CH_TAB);
		case ($urandom_range(2))
			0: push_char(CH_MINUS);
			1: push_char(CH_PLUS);
			default: ;
		endcase
		case ($urandom_range(9))
			0: n = 0;
			7, 8: n = $urandom_range(9, 6);
			9: n = $urandom_range(13, 10);
			default: n = $urandom_range(5, 1);
		endcase
		push_digits(n);
		if ($urandom_range(9) < 6) begin
			push_char(CH_DOT);
			push_digits($urandom_range(8));
		end
		if ($urandom_range(3) == 0) begin
			n = $urandom_range(3);
			push_char(char_t'($urandom_range(255, 1)));
			for (int i = 0; i < n; i++)
				push_char(char_t'($urandom_range(255, 1)));
		end
		push_char(CH_NUL);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin : monitor
		number_t got;
		number_t want;
		if (arst_n && results.valid === 1'b1 && results.ready === 1'b1) begin
			got.value = results.value;
			got.saturated = results.saturated;
			if (pending_numbers.size() == 0) begin
				$display("%0t: unexpected result, value %0d, saturated %0b",
					$time, got.value, got.saturated);
				errors++;
			end else begin
				want = pending_numbers.pop_front();
				numbers_checked++;
				if (want.saturated)
					clamped_seen++;
				if (got.value !== want.value) begin
					$display("%0t: value mismatch, expected %0d, got %0d",
						$time, want.value, got.value);
					errors++;
				end
				if (got.saturated !== want.saturated) begin
					$display("%0t: saturated mismatch, expected %0b, got %0b",
						$time, want.saturated, got.saturated);
					errors++;
				end
			end
		end
		if (arst_n && chars.valid === 1'b1 && chars.ready === 1'b1) begin
			if (parse_char(chars.ch, want))
				pending_numbers.push_back(want);
			char_taken = 1'b1;
			chars_sent++;
		end
	end

	always @(negedge clk) begin : driver
		bit go;
		char_beat_t b;
		if (arst_n) begin
			results.ready <= ($urandom_range(99) >= rx_idle_pct);
			if (!chars.valid || char_taken) begin
				char_taken = 1'b0;
				go = char_stream.size() != 0 && $urandom_range(99) >= tx_idle_pct;
				if (go && char_stream[0].drain_first && pending_numbers.size() != 0)
					go = 1'b0;
				chars.valid <= go;
				if (go) begin
					b = char_stream.pop_front();
					chars.ch <= b.ch;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.ch = CH_NUL;
		results.ready = 1'b0;
		cycles = 0;
		errors = 0;
		chars_sent = 0;
		strings_queued = 0;
		numbers_checked = 0;
		clamped_seen = 0;
		char_taken = 1'b0;
		drain_next = 1'b0;
		clear_parser();
		tx_idle_pct = 27;
		rx_idle_pct = 57;

		push_char(CH_NUL);
		push_text(" \t-1.5");
		push_text("+0.25x9");
		push_text("-");
		push_text("+");
		push_text(".");
		push_text("a");
		push_text("1.2.3");
		push_text("2147483648");
		drain_next = 1'b1;
		push_text("-2147483647.9999999");
		push_char(8'hFF);
		push_char(CH_NUL);
		push_char(8'h80);
		push_char(CH_NUL);
		while (char_stream.size() < PHASE_CHARS)
			push_random_string();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (char_stream.size() != 0)
			@(posedge clk);
		tx_idle_pct = 57;
		rx_idle_pct = 27;
		while (char_stream.size() < PHASE_CHARS)
			push_random_string();
		while (char_stream.size() != 0)
			@(posedge clk);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (char_stream.size() < PHASE_CHARS)
			push_random_string();

		while (char_stream.size() != 0 || chars.valid === 1'b1)
			@(posedge clk);
		while (pending_numbers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters in %0d strings under three stall settings.",
			chars_sent, strings_queued);
		$display("Checked %0d parsed numbers, %0d of them clamped; %0d errors.",
			numbers_checked, clamped_seen, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

FILE: ascii_decimal_to_fixed_parser_core.f
rtl/adfp_pkg.sv
rtl/adfp_char_if.sv
rtl/adfp_result_if.sv
rtl/adfp_emit.sv
rtl/ascii_decimal_to_fixed_parser_core.sv
test/tb.sv
